// File: sv/hamming_sec_codec_unit_assert.svh
// assertion macros shared by the codec checker
`ifndef HAMMING_SEC_CODEC_UNIT_ASSERT_SVH
`define HAMMING_SEC_CODEC_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define HSC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define HSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hsc_pkg.sv
// package with constants and helper functions of the hamming sec codec
`timescale 1ns / 1ps
package hsc_pkg;

  // longest codeword and the data length that fills it (57 + 6 parity bits)
  localparam int CodeBitsMax = 63;
  localparam int ParityMax   = 6;
  localparam int DataLenMax  = CodeBitsMax - ParityMax;

  localparam int LenW     = 6;
  localparam int KW       = 3;
  localparam int CfgDataW = 6;
  localparam int InDataW  = 64;   // word_in padded to whole bytes
  localparam int OutDataW = 72;   // word_out, syndrome, syndrome_bad padded

  typedef logic [CodeBitsMax-1:0] word_t;
  typedef logic [LenW-1:0]        len_t;
  typedef logic [KW-1:0]          pcnt_t;

  typedef enum logic {
    REG_DATA_LEN   = 1'b0,
    REG_PARITY_ODD = 1'b1
  } reg_idx_e;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_type_e;

  localparam len_t DataLenReset = len_t'(4);

  // smallest k with 2^k >= n + k + 1
  function automatic pcnt_t parity_count(len_t n);
    pcnt_t k;
    k = pcnt_t'(ParityMax + 1);
    for (int i = ParityMax; i >= 0; i--) begin
      if ((8'd1 << i) >= (8'(n) + 8'(i) + 8'd1)) begin
        k = pcnt_t'(i);
      end
    end
    return k;
  endfunction

  // codeword position (from 1) that holds data bit m
  function automatic int data_pos(int m);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p <= CodeBitsMax; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == m) begin
          pos = p;
        end
        cnt++;
      end
    end
    return pos;
  endfunction

  // positions covered by parity bit i
  function automatic word_t cover_mask(int i);
    word_t m;
    for (int j = 0; j < CodeBitsMax; j++) begin
      m[j] = (((j + 1) >> i) & 1) != 0;
    end
    return m;
  endfunction

endpackage

// File: sv/hamming_sec_codec_unit.sv
// hamming single-error-correcting codec with configurable data length
// an input transfer passes through the input register, then the result register, to the output
// throughput: one word per cycle while the output is not stalled, set by the input register and result register pair
// every word is independent; encode and decode are xor trees and muxes
// reset: async active low, clears both valid flags, data_len to 4 and parity_odd to 0
// config writes take effect on the next cycle and are expected only while idle
`timescale 1ns / 1ps
module hamming_sec_codec_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [hsc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hsc_pkg::InDataW-1:0]   s_axis_tdata,  // [62:0] word_in, [63] zero pad
  input  logic                          s_axis_tuser,  // [0] req_type
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hsc_pkg::OutDataW-1:0]  m_axis_tdata   // [62:0] word_out, [68:63] syndrome,
                                                       // [69] syndrome_bad, [71:70] zero pad
);
  import hsc_pkg::*;

  // configuration registers
  len_t   data_len_q;
  logic   parity_odd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_len_q   <= DataLenReset;
      parity_odd_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DATA_LEN:   data_len_q   <= cfg_wdata_i;
        REG_PARITY_ODD: parity_odd_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // derived code geometry: clamp data length to 1..57, then parity count and length
  len_t   n_eff;
  pcnt_t  k_eff;
  len_t   code_len;
  word_t  data_mask;
  word_t  len_mask;

  always_comb begin
    if (data_len_q == '0) begin
      n_eff = len_t'(1);
    end else if (data_len_q > len_t'(DataLenMax)) begin
      n_eff = len_t'(DataLenMax);
    end else begin
      n_eff = data_len_q;
    end
    k_eff    = parity_count(n_eff);
    code_len = n_eff + len_t'(k_eff);
  end

  for (genvar j = 0; j < CodeBitsMax; j++) begin : g_mask
    assign data_mask[j] = (len_t'(j) < n_eff);
    assign len_mask[j]  = (len_t'(j) < code_len);
  end

  // handshake: two-register pipeline, each stage loads when the next can take it
  logic  s1_valid_q;
  logic  s1_type_q;
  word_t s1_word_q;
  logic  out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic  out_load;
  logic  s1_load;

  assign out_load      = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || out_load;
  assign s1_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (!out_valid_q || m_axis_tready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_type_q <= s_axis_tuser;
      s1_word_q <= s_axis_tdata[CodeBitsMax-1:0];
    end
  end

  // encode: scatter data bits onto non power-of-two positions, then parity trees
  word_t dmask;
  word_t enc_scatter;
  word_t enc_word;
  logic [ParityMax-1:0] enc_par;

  assign dmask = s1_word_q & data_mask;

  always_comb begin
    enc_scatter = '0;
    for (int m = 0; m < DataLenMax; m++) begin
      enc_scatter[data_pos(m) - 1] = dmask[m];
    end
  end

  for (genvar i = 0; i < ParityMax; i++) begin : g_enc_par
    assign enc_par[i] = ^(enc_scatter & cover_mask(i));
  end

  // parity slots are zero in the scatter; only the k in use get written
  always_comb begin
    enc_word = enc_scatter;
    for (int i = 0; i < ParityMax; i++) begin
      if (pcnt_t'(i) < k_eff) begin
        enc_word[(1 << i) - 1] = enc_par[i] ^ parity_odd_q;
      end
    end
  end

  // decode: syndrome over positions in use, odd parity inverts the k low bits
  word_t cw;
  len_t  dec_raw;
  len_t  synd_inv;
  len_t  synd;
  logic  synd_fix;
  logic  synd_bad;
  word_t flip;
  word_t cw_fixed;
  word_t dec_word;

  assign cw = s1_word_q & len_mask;

  for (genvar i = 0; i < ParityMax; i++) begin : g_dec_synd
    assign dec_raw[i]  = ^(cw & cover_mask(i));
    assign synd_inv[i] = parity_odd_q && (pcnt_t'(i) < k_eff);
  end

  assign synd     = dec_raw ^ synd_inv;
  // a syndrome past the codeword end is flagged and nothing is flipped
  assign synd_fix = (synd != '0) && (synd <= code_len);
  assign synd_bad = (synd != '0) && (synd > code_len);

  for (genvar j = 0; j < CodeBitsMax; j++) begin : g_flip
    assign flip[j] = synd_fix && (synd == len_t'(j + 1));
  end

  assign cw_fixed = cw ^ flip;

  // gather data bits back; bits past the data length come from masked positions
  always_comb begin
    dec_word = '0;
    for (int m = 0; m < DataLenMax; m++) begin
      dec_word[m] = cw_fixed[data_pos(m) - 1];
    end
  end

  // result register
  logic [OutDataW-1:0] out_data_d;

  always_comb begin
    out_data_d = '0;
    if (req_type_e'(s1_type_q) == REQ_DECODE) begin
      out_data_d[CodeBitsMax-1:0]                = dec_word;
      out_data_d[CodeBitsMax+LenW-1:CodeBitsMax] = synd;
      out_data_d[CodeBitsMax+LenW]               = synd_bad;
    end else begin
      out_data_d[CodeBitsMax-1:0]                = enc_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/hsc_checker.sv
// port-level checker for the hamming sec codec, bound to the top level
`timescale 1ns / 1ps
`include "hamming_sec_codec_unit_assert.svh"
module hsc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [hsc_pkg::OutDataW-1:0]  m_axis_tdata
);
  import hsc_pkg::*;

  logic [LenW-1:0] out_synd;
  logic            out_bad;

  assign out_synd = m_axis_tdata[CodeBitsMax+LenW-1:CodeBitsMax];
  assign out_bad  = m_axis_tdata[CodeBitsMax+LenW];

  // a stalled result keeps its data
  `HSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // a flagged syndrome lies past the shortest codeword
  `HSC_ASSERT_IMPLY(a_bad_synd, clk_i, rst_ni, m_axis_tvalid && out_bad, out_synd >= LenW'(4), "syndrome_bad with small syndrome")

  // nothing comes out on the first cycle after reset
  `HSC_ASSERT_IMPLY(a_reset_empty, clk_i, rst_ni, !$past(rst_ni), !m_axis_tvalid, "result right after reset")

  // with the sink ready, an accepted word goes via both registers to the output
  `HSC_ASSERT_NEXT(a_latency, clk_i, rst_ni, s_axis_tvalid && s_axis_tready ##1 m_axis_tready, m_axis_tvalid, "result missing after two cycles")

endmodule

bind hamming_sec_codec_unit hsc_checker u_hsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
